// File: rtl/arrive_pkg.sv
package arrive_pkg;

    typedef enum logic [2:0] {
        REG_MAX_SPEED      = 3'd0,
        REG_MAX_ACCEL      = 3'd1,
        REG_SLOW_RADIUS    = 3'd2,
        REG_ARRIVE_RADIUS  = 3'd3,
        REG_TIME_TO_TARGET = 3'd4
    } reg_idx_t;

    localparam int unsigned ROOT_STEPS = 32;
    localparam int unsigned Q31_STEPS  = 31;
    localparam int unsigned Q32_STEPS  = 32;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [31:0] POS_LIMIT = 32'h7fff_ffff;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               sx;
        logic               sy;
        logic [31:0]        adx;
        logic [31:0]        ady;
    } front_t;

    typedef struct packed {
        front_t      f;
        logic [62:0] sqx;
        logic [62:0] sqy;
    } sq_t;

    typedef struct packed {
        front_t      f;
        logic [63:0] d2;
    } d2_t;

    typedef struct packed {
        front_t      f;
        logic        arrived;
        logic        far;
        logic [63:0] n;
        logic [63:0] r;
    } rt1_t;

    typedef struct packed {
        front_t      f;
        logic        arrived;
        logic        far;
        logic [31:0] dlen;
        logic [62:0] rem;
        logic [30:0] q;
    } dv1_t;

    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               sx;
        logic               sy;
        logic               arrived;
        logic [31:0]        dlen;
        logic [62:0]        remx;
        logic [62:0]        remy;
        logic [30:0]        qx;
        logic [30:0]        qy;
    } dv2_t;

    typedef struct packed {
        logic        sx;
        logic        sy;
        logic        arrived;
        logic [32:0] magx;
        logic [32:0] magy;
    } err_t;

    typedef struct packed {
        logic        sx;
        logic        sy;
        logic        ovx;
        logic        ovy;
        logic        arrived;
        logic [62:0] remx;
        logic [62:0] remy;
        logic [31:0] qx;
        logic [31:0] qy;
    } dv3_t;

    typedef struct packed {
        logic               arrived;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
    } lin_t;

    typedef struct packed {
        lin_t        l;
        logic [62:0] sqx;
        logic [62:0] sqy;
    } lsq_t;

    typedef struct packed {
        lin_t        l;
        logic [63:0] m2;
    } m2_t;

    typedef struct packed {
        lin_t        l;
        logic        clamp;
        logic [63:0] n;
        logic [63:0] r;
    } rt2_t;

    typedef struct packed {
        lin_t        l;
        logic        clamp;
        logic [31:0] m;
        logic [62:0] remx;
        logic [62:0] remy;
        logic [30:0] qx;
        logic [30:0] qy;
    } dv4_t;

endpackage

// File: rtl/arrive_steering_top.sv
// channel   signals                                         handshake
// config    psel penable pwrite paddr pwdata prdata pready  apb write, pready tied high
// request   start busy + agent/target fields                transfer when start & !busy
// result    done accel_x accel_y arrived                    one-cycle strobe on done
//
// the depth is set by two 32-step square roots and four long divisions, one
// quotient or root bit per register stage.
// a new request is taken every cycle; busy never rises.
// rst_n clears the valid chain and the registers; payload stages are not reset.
// the result side cannot stall, so nothing in the pipe ever waits.
module arrive_steering_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] agent_pos_x,
    input  logic [31:0] agent_pos_y,
    input  logic [31:0] agent_vel_x,
    input  logic [31:0] agent_vel_y,
    input  logic [31:0] target_x,
    input  logic [31:0] target_y,
    output logic        done,
    output logic [31:0] accel_x,
    output logic [31:0] accel_y,
    output logic        arrived
);
    import arrive_pkg::*;

    localparam int LAT = 4 + ROOT_STEPS + 1 + Q31_STEPS + 1 + Q31_STEPS + 2 + Q32_STEPS
                       + 4 + ROOT_STEPS + 1 + Q31_STEPS + 1;

    // configuration
    logic [30:0] max_speed_reg, max_accel_reg, slow_radius_reg;
    logic [30:0] arrive_radius_reg, time_to_target_reg;
    logic [61:0] ar2_reg, sr2_reg, ma2_reg;
    logic [30:0] t_div;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign t_div  = (time_to_target_reg == '0) ? 31'd1 : time_to_target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg      <= 31'd262144;
            max_accel_reg      <= 31'd131072;
            slow_radius_reg    <= 31'd655360;
            arrive_radius_reg  <= 31'd65536;
            time_to_target_reg <= 31'd6554;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_MAX_SPEED:      max_speed_reg      <= pwdata[30:0];
                REG_MAX_ACCEL:      max_accel_reg      <= pwdata[30:0];
                REG_SLOW_RADIUS:    slow_radius_reg    <= pwdata[30:0];
                REG_ARRIVE_RADIUS:  arrive_radius_reg  <= pwdata[30:0];
                REG_TIME_TO_TARGET: time_to_target_reg <= pwdata[30:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_MAX_SPEED:      prdata = {1'b0, max_speed_reg};
            REG_MAX_ACCEL:      prdata = {1'b0, max_accel_reg};
            REG_SLOW_RADIUS:    prdata = {1'b0, slow_radius_reg};
            REG_ARRIVE_RADIUS:  prdata = {1'b0, arrive_radius_reg};
            REG_TIME_TO_TARGET: prdata = {1'b0, time_to_target_reg};
            default:            prdata = '0;
        endcase
    end

    // squared limits, settled long before any transfer reaches the compares
    always_ff @(posedge clk)
    begin
        ar2_reg <= 62'(arrive_radius_reg) * 62'(arrive_radius_reg);
        sr2_reg <= 62'(slow_radius_reg) * 62'(slow_radius_reg);
        ma2_reg <= 62'(max_accel_reg) * 62'(max_accel_reg);
    end

    // valid chain
    logic [LAT-1:0] vld_reg;

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start};
    end

    // front: saturated differences, squares, distance squared, range flags
    front_t      front_next, front_reg;
    sq_t         sq_reg;
    d2_t         d2_reg;
    logic [32:0] diff_x, diff_y;
    logic [31:0] dxs, dys;

    always_comb
    begin
        diff_x = {target_x[31], target_x} - {agent_pos_x[31], agent_pos_x};
        diff_y = {target_y[31], target_y} - {agent_pos_y[31], agent_pos_y};
        if (diff_x[32] != diff_x[31])
            dxs = diff_x[32] ? MAG_LIMIT : POS_LIMIT;
        else
            dxs = diff_x[31:0];
        if (diff_y[32] != diff_y[31])
            dys = diff_y[32] ? MAG_LIMIT : POS_LIMIT;
        else
            dys = diff_y[31:0];
        front_next.vx  = agent_vel_x;
        front_next.vy  = agent_vel_y;
        front_next.sx  = dxs[31];
        front_next.sy  = dys[31];
        front_next.adx = dxs[31] ? -dxs : dxs;
        front_next.ady = dys[31] ? -dys : dys;
    end

    always_ff @(posedge clk)
    begin
        front_reg  <= front_next;
        sq_reg.f   <= front_reg;
        sq_reg.sqx <= 63'(64'(front_reg.adx) * 64'(front_reg.adx));
        sq_reg.sqy <= 63'(64'(front_reg.ady) * 64'(front_reg.ady));
        d2_reg.f   <= sq_reg.f;
        d2_reg.d2  <= 64'(sq_reg.sqx) + 64'(sq_reg.sqy);
    end

    // distance root
    rt1_t rt1_reg [0:ROOT_STEPS];

    always_ff @(posedge clk)
    begin
        rt1_reg[0].f       <= d2_reg.f;
        rt1_reg[0].arrived <= (d2_reg.d2 == '0) || (d2_reg.d2 < 64'(ar2_reg));
        rt1_reg[0].far     <= d2_reg.d2 > 64'(sr2_reg);
        rt1_reg[0].n       <= d2_reg.d2;
        rt1_reg[0].r       <= '0;
    end

    genvar k;
    generate
        for (k = 0; k < ROOT_STEPS; k++)
        begin : g_root1
            localparam logic [63:0] BIT = 64'd1 << (2 * (ROOT_STEPS - 1 - k));
            rt1_t rt1_next;
            always_comb
            begin
                rt1_next = rt1_reg[k];
                if (rt1_reg[k].n >= rt1_reg[k].r + BIT)
                begin
                    rt1_next.n = rt1_reg[k].n - (rt1_reg[k].r + BIT);
                    rt1_next.r = (rt1_reg[k].r >> 1) + BIT;
                end
                else
                begin
                    rt1_next.r = rt1_reg[k].r >> 1;
                end
            end
            always_ff @(posedge clk)
            begin
                rt1_reg[k+1] <= rt1_next;
            end
        end
    endgenerate

    // ramp speed: max_speed * dist / slow_radius
    dv1_t dv1_reg [0:Q31_STEPS];

    always_ff @(posedge clk)
    begin
        dv1_reg[0].f       <= rt1_reg[ROOT_STEPS].f;
        dv1_reg[0].arrived <= rt1_reg[ROOT_STEPS].arrived;
        dv1_reg[0].far     <= rt1_reg[ROOT_STEPS].far;
        dv1_reg[0].dlen    <= rt1_reg[ROOT_STEPS].r[31:0];
        dv1_reg[0].rem     <= 63'(max_speed_reg) * 63'(rt1_reg[ROOT_STEPS].r[31:0]);
        dv1_reg[0].q       <= '0;
    end

    generate
        for (k = 0; k < Q31_STEPS; k++)
        begin : g_div1
            localparam int SH = Q31_STEPS - 1 - k;
            dv1_t dv1_next;
            logic [62:0] dsh;
            always_comb
            begin
                dv1_next = dv1_reg[k];
                dsh = 63'(slow_radius_reg) << SH;
                if (dv1_reg[k].rem >= dsh)
                begin
                    dv1_next.rem   = dv1_reg[k].rem - dsh;
                    dv1_next.q[SH] = 1'b1;
                end
            end
            always_ff @(posedge clk)
            begin
                dv1_reg[k+1] <= dv1_next;
            end
        end
    endgenerate

    // desired velocity: |d| * speed / dist per axis
    dv2_t        dv2_reg [0:Q31_STEPS];
    logic [30:0] speed;

    assign speed = dv1_reg[Q31_STEPS].far ? max_speed_reg : dv1_reg[Q31_STEPS].q;

    always_ff @(posedge clk)
    begin
        dv2_reg[0].vx      <= dv1_reg[Q31_STEPS].f.vx;
        dv2_reg[0].vy      <= dv1_reg[Q31_STEPS].f.vy;
        dv2_reg[0].sx      <= dv1_reg[Q31_STEPS].f.sx;
        dv2_reg[0].sy      <= dv1_reg[Q31_STEPS].f.sy;
        dv2_reg[0].arrived <= dv1_reg[Q31_STEPS].arrived;
        dv2_reg[0].dlen    <= dv1_reg[Q31_STEPS].dlen;
        dv2_reg[0].remx    <= 63'(dv1_reg[Q31_STEPS].f.adx) * 63'(speed);
        dv2_reg[0].remy    <= 63'(dv1_reg[Q31_STEPS].f.ady) * 63'(speed);
        dv2_reg[0].qx      <= '0;
        dv2_reg[0].qy      <= '0;
    end

    generate
        for (k = 0; k < Q31_STEPS; k++)
        begin : g_div2
            localparam int SH = Q31_STEPS - 1 - k;
            dv2_t dv2_next;
            logic [62:0] dsh;
            always_comb
            begin
                dv2_next = dv2_reg[k];
                dsh = 63'(dv2_reg[k].dlen) << SH;
                if (dv2_reg[k].remx >= dsh)
                begin
                    dv2_next.remx   = dv2_reg[k].remx - dsh;
                    dv2_next.qx[SH] = 1'b1;
                end
                if (dv2_reg[k].remy >= dsh)
                begin
                    dv2_next.remy   = dv2_reg[k].remy - dsh;
                    dv2_next.qy[SH] = 1'b1;
                end
            end
            always_ff @(posedge clk)
            begin
                dv2_reg[k+1] <= dv2_next;
            end
        end
    endgenerate

    // velocity error and its magnitude
    err_t        err_next, err_reg;
    logic [31:0] tvx, tvy;
    logic [32:0] ex, ey;

    always_comb
    begin
        tvx = dv2_reg[Q31_STEPS].sx ? -{1'b0, dv2_reg[Q31_STEPS].qx}
                                    : {1'b0, dv2_reg[Q31_STEPS].qx};
        tvy = dv2_reg[Q31_STEPS].sy ? -{1'b0, dv2_reg[Q31_STEPS].qy}
                                    : {1'b0, dv2_reg[Q31_STEPS].qy};
        ex = {tvx[31], tvx} - {dv2_reg[Q31_STEPS].vx[31], dv2_reg[Q31_STEPS].vx};
        ey = {tvy[31], tvy} - {dv2_reg[Q31_STEPS].vy[31], dv2_reg[Q31_STEPS].vy};
        err_next.sx      = ex[32];
        err_next.sy      = ey[32];
        err_next.arrived = dv2_reg[Q31_STEPS].arrived;
        err_next.magx    = ex[32] ? -ex : ex;
        err_next.magy    = ey[32] ? -ey : ey;
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
    end

    // error / time_to_target, with overflow flagged up front
    dv3_t        dv3_reg [0:Q32_STEPS];
    logic [62:0] numx, numy;

    assign numx = 63'(err_reg.magx) << FRAC_BITS;
    assign numy = 63'(err_reg.magy) << FRAC_BITS;

    always_ff @(posedge clk)
    begin
        dv3_reg[0].sx      <= err_reg.sx;
        dv3_reg[0].sy      <= err_reg.sy;
        dv3_reg[0].ovx     <= numx >= {t_div, 32'd0};
        dv3_reg[0].ovy     <= numy >= {t_div, 32'd0};
        dv3_reg[0].arrived <= err_reg.arrived;
        dv3_reg[0].remx    <= numx;
        dv3_reg[0].remy    <= numy;
        dv3_reg[0].qx      <= '0;
        dv3_reg[0].qy      <= '0;
    end

    generate
        for (k = 0; k < Q32_STEPS; k++)
        begin : g_div3
            localparam int SH = Q32_STEPS - 1 - k;
            dv3_t dv3_next;
            logic [62:0] dsh;
            always_comb
            begin
                dv3_next = dv3_reg[k];
                dsh = 63'(t_div) << SH;
                if (dv3_reg[k].remx >= dsh)
                begin
                    dv3_next.remx   = dv3_reg[k].remx - dsh;
                    dv3_next.qx[SH] = 1'b1;
                end
                if (dv3_reg[k].remy >= dsh)
                begin
                    dv3_next.remy   = dv3_reg[k].remy - dsh;
                    dv3_next.qy[SH] = 1'b1;
                end
            end
            always_ff @(posedge clk)
            begin
                dv3_reg[k+1] <= dv3_next;
            end
        end
    endgenerate

    // saturated linear acceleration, its squared magnitude, clamp flag
    lin_t        lin_next, lin_reg;
    lsq_t        lsq_reg;
    m2_t         m2_reg;
    logic [31:0] smx, smy, alx, aly;

    always_comb
    begin
        smx = (dv3_reg[Q32_STEPS].ovx || dv3_reg[Q32_STEPS].qx > MAG_LIMIT)
              ? MAG_LIMIT : dv3_reg[Q32_STEPS].qx;
        smy = (dv3_reg[Q32_STEPS].ovy || dv3_reg[Q32_STEPS].qy > MAG_LIMIT)
              ? MAG_LIMIT : dv3_reg[Q32_STEPS].qy;
        lin_next.arrived = dv3_reg[Q32_STEPS].arrived;
        if (dv3_reg[Q32_STEPS].sx)
            lin_next.lx = -smx;
        else
            lin_next.lx = (smx == MAG_LIMIT) ? POS_LIMIT : smx;
        if (dv3_reg[Q32_STEPS].sy)
            lin_next.ly = -smy;
        else
            lin_next.ly = (smy == MAG_LIMIT) ? POS_LIMIT : smy;
        alx = lin_reg.lx[31] ? -lin_reg.lx : lin_reg.lx;
        aly = lin_reg.ly[31] ? -lin_reg.ly : lin_reg.ly;
    end

    rt2_t rt2_reg [0:ROOT_STEPS];

    always_ff @(posedge clk)
    begin
        lin_reg          <= lin_next;
        lsq_reg.l        <= lin_reg;
        lsq_reg.sqx      <= 63'(64'(alx) * 64'(alx));
        lsq_reg.sqy      <= 63'(64'(aly) * 64'(aly));
        m2_reg.l         <= lsq_reg.l;
        m2_reg.m2        <= 64'(lsq_reg.sqx) + 64'(lsq_reg.sqy);
        rt2_reg[0].l     <= m2_reg.l;
        rt2_reg[0].clamp <= m2_reg.m2 > 64'(ma2_reg);
        rt2_reg[0].n     <= m2_reg.m2;
        rt2_reg[0].r     <= '0;
    end

    generate
        for (k = 0; k < ROOT_STEPS; k++)
        begin : g_root2
            localparam logic [63:0] BIT = 64'd1 << (2 * (ROOT_STEPS - 1 - k));
            rt2_t rt2_next;
            always_comb
            begin
                rt2_next = rt2_reg[k];
                if (rt2_reg[k].n >= rt2_reg[k].r + BIT)
                begin
                    rt2_next.n = rt2_reg[k].n - (rt2_reg[k].r + BIT);
                    rt2_next.r = (rt2_reg[k].r >> 1) + BIT;
                end
                else
                begin
                    rt2_next.r = rt2_reg[k].r >> 1;
                end
            end
            always_ff @(posedge clk)
            begin
                rt2_reg[k+1] <= rt2_next;
            end
        end
    endgenerate

    // clamp: |lin| * max_acceleration / magnitude
    dv4_t        dv4_reg [0:Q31_STEPS];
    logic [31:0] clx, cly;

    assign clx = rt2_reg[ROOT_STEPS].l.lx[31] ? -rt2_reg[ROOT_STEPS].l.lx
                                              : rt2_reg[ROOT_STEPS].l.lx;
    assign cly = rt2_reg[ROOT_STEPS].l.ly[31] ? -rt2_reg[ROOT_STEPS].l.ly
                                              : rt2_reg[ROOT_STEPS].l.ly;

    always_ff @(posedge clk)
    begin
        dv4_reg[0].l     <= rt2_reg[ROOT_STEPS].l;
        dv4_reg[0].clamp <= rt2_reg[ROOT_STEPS].clamp;
        dv4_reg[0].m     <= rt2_reg[ROOT_STEPS].r[31:0];
        dv4_reg[0].remx  <= 63'(clx) * 63'(max_accel_reg);
        dv4_reg[0].remy  <= 63'(cly) * 63'(max_accel_reg);
        dv4_reg[0].qx    <= '0;
        dv4_reg[0].qy    <= '0;
    end

    generate
        for (k = 0; k < Q31_STEPS; k++)
        begin : g_div4
            localparam int SH = Q31_STEPS - 1 - k;
            dv4_t dv4_next;
            logic [62:0] dsh;
            always_comb
            begin
                dv4_next = dv4_reg[k];
                dsh = 63'(dv4_reg[k].m) << SH;
                if (dv4_reg[k].remx >= dsh)
                begin
                    dv4_next.remx   = dv4_reg[k].remx - dsh;
                    dv4_next.qx[SH] = 1'b1;
                end
                if (dv4_reg[k].remy >= dsh)
                begin
                    dv4_next.remy   = dv4_reg[k].remy - dsh;
                    dv4_next.qy[SH] = 1'b1;
                end
            end
            always_ff @(posedge clk)
            begin
                dv4_reg[k+1] <= dv4_next;
            end
        end
    endgenerate

    // result register
    logic [31:0] accel_x_next, accel_y_next, accel_x_reg, accel_y_reg;
    logic        arrived_reg;
    dv4_t        fin;

    assign fin = dv4_reg[Q31_STEPS];

    always_comb
    begin
        if (fin.l.arrived)
        begin
            accel_x_next = '0;
            accel_y_next = '0;
        end
        else if (fin.clamp)
        begin
            accel_x_next = fin.l.lx[31] ? -{1'b0, fin.qx} : {1'b0, fin.qx};
            accel_y_next = fin.l.ly[31] ? -{1'b0, fin.qy} : {1'b0, fin.qy};
        end
        else
        begin
            accel_x_next = fin.l.lx;
            accel_y_next = fin.l.ly;
        end
    end

    always_ff @(posedge clk)
    begin
        accel_x_reg <= accel_x_next;
        accel_y_reg <= accel_y_next;
        arrived_reg <= fin.l.arrived;
    end

    assign accel_x = accel_x_reg;
    assign accel_y = accel_y_reg;
    assign arrived = arrived_reg;

endmodule

// File: tb/sv/arrive_steering_top_tb.sv
module arrive_steering_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import arrive_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] tx;
        logic [31:0] ty;
    } steer_req_t;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic        arr;
    } steer_res_t;

    typedef struct packed {
        steer_req_t req;
        logic       has_exp;
        steer_res_t exp;
    } steer_row_t;

    // register slots past the last one, writes there must be dropped
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int QUIET_LIMIT = 4000;
    localparam int N_ROWS = 16;
    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam steer_res_t ARRIVED_RES = '{32'd0, 32'd0, 1'b1};
    localparam steer_res_t NO_RES = '{32'd0, 32'd0, 1'b0};

    localparam steer_row_t DIRECTED [N_ROWS] = '{
        '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0}, 1'b1, ARRIVED_RES},
        '{'{MINN, MINN, MAXP, MINN, MINN, MINN}, 1'b1, ARRIVED_RES},
        '{'{MAXP, MAXP, MINN, MAXP, MAXP, MAXP}, 1'b1, ARRIVED_RES},
        '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'h8000, 32'h8000}, 1'b1, ARRIVED_RES},
        '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'hffff, 32'd0}, 1'b1, ARRIVED_RES},
        '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'h10000, 32'd0}, 1'b0, NO_RES},
        '{'{MINN, MINN, 32'd0, 32'd0, MAXP, MAXP}, 1'b0, NO_RES},
        '{'{MAXP, MAXP, MINN, MINN, MINN, MINN}, 1'b0, NO_RES},
        '{'{MAXP, MINN, MAXP, MAXP, MINN, MAXP}, 1'b0, NO_RES},
        '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'h50000, 32'd0}, 1'b0, NO_RES},
        '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h640000}, 1'b0, NO_RES},
        '{'{32'h10000, 32'h10000, MAXP, MINN, 32'h30000, 32'hfffe0000}, 1'b0, NO_RES},
        '{'{32'd0, 32'd0, 32'h20000, 32'd0, 32'hfffb0000, 32'hfffd0000}, 1'b0, NO_RES},
        '{'{32'd0, 32'd0, 32'h40000, 32'd0, 32'h80000, 32'd0}, 1'b0, NO_RES},
        '{'{32'hffff0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'h7fff}, 1'b0, NO_RES},
        '{'{32'd0, 32'd0, MINN, MINN, 32'h10, 32'hfffffff0}, 1'b0, NO_RES}
    };

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        start, busy, done, arrived;
    logic [31:0] agent_pos_x, agent_pos_y, agent_vel_x, agent_vel_y, target_x, target_y;
    logic [31:0] accel_x, accel_y;

    u64_t       steer_regs [5];
    steer_res_t accel_fifo [$];
    int         mismatches;
    int         items_sent;
    int         arrived_seen;
    int         results_seen;
    int         quiet_cycles;
    bit         allow_idle;

    arrive_steering_top dut (.*);

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic u64_t floor_sqrt(u64_t n);
        u64_t r;
        u64_t b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // trunc(a * m / d) toward zero
    function automatic longint mul_div(longint a, u64_t m, u64_t d);
        u64_t mag;
        u64_t q;
        mag = (a < 0) ? u64_t'(-a) : u64_t'(a);
        q = mag * m / d;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint per_time(longint e, u64_t t);
        u64_t mag;
        u64_t q;
        mag = (e < 0) ? u64_t'(-e) : u64_t'(e);
        q = (mag << 16) / t;
        if (q > 64'h8000_0000)
            q = 64'h8000_0000;
        return clip32((e < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic steer_res_t steer_accel(steer_req_t r);
        steer_res_t res;
        longint dx, dy, tvx, tvy, lx, ly;
        u64_t d2, dlen, speed, t, m2;
        dx = clip32(longint'($signed(r.tx)) - longint'($signed(r.px)));
        dy = clip32(longint'($signed(r.ty)) - longint'($signed(r.py)));
        d2 = u64_t'(dx * dx) + u64_t'(dy * dy);
        res = NO_RES;
        if (d2 == 0 || d2 < steer_regs[REG_ARRIVE_RADIUS] * steer_regs[REG_ARRIVE_RADIUS])
            return ARRIVED_RES;
        dlen = floor_sqrt(d2);
        if (d2 > steer_regs[REG_SLOW_RADIUS] * steer_regs[REG_SLOW_RADIUS])
            speed = steer_regs[REG_MAX_SPEED];
        else
            speed = steer_regs[REG_MAX_SPEED] * dlen / steer_regs[REG_SLOW_RADIUS];
        tvx = mul_div(dx, speed, dlen);
        tvy = mul_div(dy, speed, dlen);
        t = (steer_regs[REG_TIME_TO_TARGET] != 0) ? steer_regs[REG_TIME_TO_TARGET] : 1;
        lx = per_time(tvx - longint'($signed(r.vx)), t);
        ly = per_time(tvy - longint'($signed(r.vy)), t);
        m2 = u64_t'(lx * lx) + u64_t'(ly * ly);
        if (m2 > steer_regs[REG_MAX_ACCEL] * steer_regs[REG_MAX_ACCEL])
        begin
            dlen = floor_sqrt(m2);
            lx = mul_div(lx, steer_regs[REG_MAX_ACCEL], dlen);
            ly = mul_div(ly, steer_regs[REG_MAX_ACCEL], dlen);
        end
        res.ax = lx[31:0];
        res.ay = ly[31:0];
        return res;
    endfunction

    function automatic logic [31:0] small_val(int unsigned span);
        logic [31:0] v;
        v = $urandom_range(0, (32'd1 << span) - 1);
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    function automatic steer_req_t rand_req();
        steer_req_t r;
        int unsigned sel;
        int unsigned span;
        sel = $urandom_range(0, 9);
        span = $urandom_range(8, 30);
        r.px = (sel < 2) ? $urandom() : small_val(24);
        r.py = (sel < 2) ? $urandom() : small_val(24);
        if (sel < 2)
        begin
            r.tx = $urandom();
            r.ty = $urandom();
        end
        else if (sel == 2)
        begin
            r.tx = r.px;
            r.ty = r.py;
        end
        else
        begin
            r.tx = r.px + small_val(span);
            r.ty = r.py + small_val($urandom_range(0, 1) != 0 ? span : 4);
        end
        case ($urandom_range(0, 5))
            0: begin r.vx = $urandom(); r.vy = $urandom(); end
            1: begin r.vx = ($urandom_range(0, 1) != 0) ? MAXP : MINN; r.vy = MINN; end
            default: begin r.vx = small_val(span); r.vy = small_val(span); end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rand_reg(bit is_time);
        case ($urandom_range(0, 5))
            0: return is_time ? 32'd0 : 32'd0;
            1: return MAXP;
            2: return $urandom();
            3: return 32'h8000_0000 | $urandom_range(1, 32'h0100_0000);
            default: return $urandom_range(1, 32'h0100_0000);
        endcase
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx <= REG_TIME_TO_TARGET)
            steer_regs[idx] = {33'd0, val[30:0]};
    endtask

    task automatic write_all(logic [31:0] ms, logic [31:0] ma, logic [31:0] sr,
                             logic [31:0] ar, logic [31:0] tt);
        reg_write(REG_MAX_SPEED, ms);
        reg_write(REG_MAX_ACCEL, ma);
        reg_write(REG_SLOW_RADIUS, sr);
        reg_write(REG_ARRIVE_RADIUS, ar);
        reg_write(REG_TIME_TO_TARGET, tt);
    endtask

    task automatic send_item(steer_req_t r, logic has_exp, steer_res_t exp);
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        agent_pos_x <= r.px;
        agent_pos_y <= r.py;
        agent_vel_x <= r.vx;
        agent_vel_y <= r.vy;
        target_x <= r.tx;
        target_y <= r.ty;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        accel_fifo.push_back(has_exp ? exp : steer_accel(r));
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (accel_fifo.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_item(rand_req(), 1'b0, NO_RES);
        drain();
    endtask

    always @(posedge clk)
    begin
        steer_res_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (arrived)
                arrived_seen++;
            if (accel_fifo.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %h %h %b", accel_x, accel_y, arrived);
            end
            else
            begin
                want = accel_fifo.pop_front();
                if (accel_x !== want.ax || accel_y !== want.ay || arrived !== want.arr)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h %h %b got %h %h %b",
                                 want.ax, want.ay, want.arr, accel_x, accel_y, arrived);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        start <= 1'b0;
        agent_pos_x <= '0;
        agent_pos_y <= '0;
        agent_vel_x <= '0;
        agent_vel_y <= '0;
        target_x <= '0;
        target_y <= '0;
        quiet_cycles <= 0;
        mismatches = 0;
        items_sent = 0;
        arrived_seen = 0;
        results_seen = 0;
        allow_idle = 1'b1;
        steer_regs[REG_MAX_SPEED] = 262144;
        steer_regs[REG_MAX_ACCEL] = 131072;
        steer_regs[REG_SLOW_RADIUS] = 655360;
        steer_regs[REG_ARRIVE_RADIUS] = 65536;
        steer_regs[REG_TIME_TO_TARGET] = 6554;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_item(DIRECTED[i].req, DIRECTED[i].has_exp, DIRECTED[i].exp);
        drain();
        random_phase(150);

        // all registers but the arrive radius at the top, spare slots must not disturb anything
        write_all(MAXP, MAXP, MAXP, 32'd0, MAXP);
        reg_write(REG_SPARE_LO, 32'h0000_0001);
        reg_write(REG_SPARE_HI, 32'hffff_ffff);
        random_phase(130);

        // zero time to target behaves as the smallest step
        write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        random_phase(100);
        write_all(MAXP, 32'h10000, 32'd0, 32'h100, 32'd0);
        random_phase(100);

        for (int p = 0; p < 7; p++)
        begin
            write_all(rand_reg(1'b0), rand_reg(1'b0), rand_reg(1'b0),
                      rand_reg(1'b0) >> $urandom_range(0, 12), rand_reg(1'b1));
            random_phase(90);
        end

        write_all(32'd262144, 32'd131072, 32'd655360, 32'd65536, 32'd6554);
        allow_idle = 1'b0;
        random_phase(200);

        repeat (210) @(posedge clk);
        $display("covered %0d requests, %0d results, %0d of them arrived, 11 register settings",
                 items_sent, results_seen, arrived_seen);
        if (mismatches == 0 && accel_fifo.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
